[rtl/core/sitda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared constants for the signed-to-decimal-ASCII converter
// Character codes, magnitude width and the power-of-ten ladder used by the
// digit sequencer.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAG_BITS       = 64;
  localparam int CHAR_BITS      = 7;
  localparam int NUM_DIGITS     = 19;

  localparam logic [4:0] TOP_DIGIT = 5'(NUM_DIGITS - 1);

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_LF    = 7'h0A;

  localparam logic [MAG_BITS-1:0] POW10 [NUM_DIGITS] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000,
    64'd10000000000000000,
    64'd100000000000000000,
    64'd1000000000000000000
  };

  // Weight of one digit bit: (2^step) * 10^pos. Largest is 8 * 10^18.
  function automatic logic [MAG_BITS-1:0] ladder(input logic [4:0] pos,
                                                 input logic [1:0] step);
    return POW10[pos] << step;
  endfunction

endpackage

[rtl/core/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// One item at a time: a new value is accepted only in idle, once the line
//   feed of the previous item has been loaded. Each digit position runs the
//   compare-subtract steps and then an emit step; the output side can stall
//   the sign, the shown digits and the line feed.
// A single 65-bit compare-subtract unit, used four times per digit, serves
//   every position. Synchronous active-high rst returns the block to idle.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's complement value per item into a run of ASCII
// characters (optional '-', digits without leading zeros, line feed).
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value (low VALUE_BITS bits used)
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] character, [7] zero fill
  output logic        m_tlast    // last: set on the closing line feed
);
  import sitda_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIGN,
    S_CALC,
    S_EMIT,
    S_LF
  } state_t;

  state_t              state;
  logic [MAG_BITS-1:0] rem;        // magnitude still to split
  logic [4:0]          pos;        // current decimal position, 18 down to 0
  logic [1:0]          step;       // digit bit under test, 3 down to 0
  logic [3:0]          digit;      // digit being built
  logic                started;    // a digit has gone out

  logic [VALUE_BITS-1:0] in_val;
  logic [VALUE_BITS-1:0] in_mag;
  logic                  in_neg;
  logic [MAG_BITS:0]     diff;
  logic                  fits;
  logic                  out_free;
  logic                  emit_digit;
  logic                  load_char;

  // Input value: keep the low VALUE_BITS bits, negate toward a magnitude.
  // The most negative value negates to itself, which read unsigned is exact.
  assign in_val = s_tdata[VALUE_BITS-1:0];
  assign in_neg = in_val[VALUE_BITS-1];
  assign in_mag = in_neg ? (~in_val + 1'b1) : in_val;

  // Shared compare-subtract unit: does the ladder weight fit in rem?
  assign diff = {1'b0, rem} - {1'b0, ladder(pos, step)};
  assign fits = ~diff[MAG_BITS];

  // Output slot takes a new character when empty or being drained this cycle.
  assign out_free = ~m_tvalid | m_tready;

  // Suppress leading zeros, but always show the units digit.
  assign emit_digit = (digit != 4'd0) | started | (pos == 5'd0);

  // A new character enters the output slot this cycle.
  assign load_char = out_free & ((state == S_SIGN) | (state == S_LF) |
                                 ((state == S_EMIT) & emit_digit));

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      started  <= 1'b0;
    end else begin
      // Fill the output slot on a load, drop valid once the item is taken.
      if (load_char) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            rem     <= MAG_BITS'(in_mag);
            pos     <= TOP_DIGIT;
            step    <= 2'd3;
            digit   <= 4'd0;
            started <= 1'b0;
            state   <= in_neg ? S_SIGN : S_CALC;
          end
        end
        S_SIGN: begin
          // Hold until the output slot frees up, then send the minus sign.
          if (out_free) begin
            m_tdata  <= {1'b0, CHAR_MINUS};
            m_tlast  <= 1'b0;
            state    <= S_CALC;
          end
        end
        S_CALC: begin
          // Restoring step: subtract the weight when it fits, set the bit.
          if (fits) begin
            rem         <= diff[MAG_BITS-1:0];
            digit[step] <= 1'b1;
          end
          if (step == 2'd0) begin
            state <= S_EMIT;
          end else begin
            step <= step - 2'd1;
          end
        end
        S_EMIT: begin
          if (!emit_digit || out_free) begin
            if (emit_digit) begin
              m_tdata  <= {1'b0, CHAR_ZERO + CHAR_BITS'(digit)};
              m_tlast  <= 1'b0;
              started  <= 1'b1;
            end
            if (pos == 5'd0) begin
              state <= S_LF;
            end else begin
              pos   <= pos - 5'd1;
              step  <= 2'd3;
              digit <= 4'd0;
              state <= S_CALC;
            end
          end
        end
        S_LF: begin
          // Close the run with the line feed and go back to idle.
          if (out_free) begin
            m_tdata  <= {1'b0, CHAR_LF};
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A digit under construction never exceeds nine.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (digit <= 4'd9))
    else $error("digit out of range at emit");

  // Only the line feed carries the last flag.
  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[6:0] == CHAR_LF))
    else $error("last flag on a character other than line feed");

  // The position counter stays inside the ladder.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC || state == S_EMIT) |-> (pos <= TOP_DIGIT))
    else $error("digit position beyond ladder");

  // At each emit the remainder is below the current position's weight.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (rem < POW10[pos]))
    else $error("remainder not reduced below current weight");

  // An accepted item always starts a conversion.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != S_IDLE))
    else $error("accepted item did not start a conversion");

endmodule
